// ===== rtl/core/qekq_pkg.sv =====
package qekq_pkg;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_DEBOUNCE_MS  = 2'd0;
  localparam cfg_idx_t CFG_HOLD_MS      = 2'd1;
  localparam cfg_idx_t CFG_DETENT_STEPS = 2'd2;

  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] DEBOUNCE_MS_RST  = 16'd30;
  localparam logic [15:0] HOLD_MS_RST      = 16'd700;
  localparam logic [3:0]  DETENT_STEPS_RST = 4'd4;

  localparam logic [1:0] AB_RST = 2'b11;

  // Bounds of the detent count
  localparam logic signed [4:0] DETENT_MIN = 5'sd1;
  localparam logic signed [4:0] DETENT_MAX = 5'sd8;

  typedef logic signed [4:0] step_acc_t;
  typedef logic signed [1:0] step_t;

  // Quadrature transition table, indexed by {previous AB, current AB}
  localparam step_t QUAD_TBL [16] = '{
    2'sd0,  -2'sd1,  2'sd1,  2'sd0,
    2'sd1,   2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
    2'sd0,   2'sd1, -2'sd1,  2'sd0
  };

  typedef struct packed {
    logic pressed;
    logic held;
  } key_evt_t;

endpackage

// ===== rtl/core/qekq_in_if.sv =====
interface qekq_in_if;
  logic        valid;
  logic        ready;
  logic        enc_a;
  logic        enc_b;
  logic        select_key;
  logic        back_key;
  logic [31:0] now_ms;

  modport source (output valid, enc_a, enc_b, select_key, back_key, now_ms, input ready);
  modport sink (input valid, enc_a, enc_b, select_key, back_key, now_ms, output ready);
endinterface

// ===== rtl/core/qekq_out_if.sv =====
interface qekq_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] encoder_step;
  logic              select_pressed;
  logic              select_held;
  logic              back_pressed;
  logic              back_held;

  modport source (output valid, encoder_step, select_pressed, select_held, back_pressed,
                  back_held, input ready);
  modport sink (input valid, encoder_step, select_pressed, select_held, back_pressed,
                back_held, output ready);
endinterface

// ===== rtl/core/qekq_key.sv =====
module qekq_key (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               pin,
  input  logic [31:0]        now_ms,
  input  logic [15:0]        debounce_ms,
  input  logic [15:0]        hold_ms,
  output qekq_pkg::key_evt_t evt
);
  import qekq_pkg::*;

  logic        level_r, level_nxt;
  logic [31:0] change_time_r, change_time_nxt;
  logic [31:0] down_time_r, down_time_nxt;
  logic        hold_done_r, hold_done_nxt;

  logic [31:0] since_change;
  logic [31:0] since_down;
  logic        accept_chg;
  logic        press;
  logic        hold_hit;

  assign since_change = now_ms - change_time_r;
  assign since_down   = now_ms - down_time_r;
  assign accept_chg   = (pin != level_r) &&
                        ((since_change[31:16] != 16'd0) || (since_change[15:0] > debounce_ms));
  assign press        = accept_chg && !pin;

  // A fresh press measures zero elapsed time; an accepted release drops the hold
  always_comb begin
    if (press) begin
      hold_hit = (hold_ms == 16'd0);
    end else begin
      hold_hit = !accept_chg && !level_r && !hold_done_r &&
                 ((since_down[31:16] != 16'd0) || (since_down[15:0] >= hold_ms));
    end
  end

  always_comb begin
    level_nxt       = level_r;
    change_time_nxt = change_time_r;
    down_time_nxt   = down_time_r;
    hold_done_nxt   = hold_done_r;
    if (accept_chg) begin
      level_nxt       = pin;
      change_time_nxt = now_ms;
    end
    if (press) begin
      down_time_nxt = now_ms;
      hold_done_nxt = 1'b0;
    end
    if (hold_hit) begin
      hold_done_nxt = 1'b1;
    end
  end

  assign evt.pressed = press;
  assign evt.held    = hold_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r       <= 1'b1;
      change_time_r <= 32'd0;
      down_time_r   <= 32'd0;
      hold_done_r   <= 1'b0;
    end else if (en) begin
      level_r       <= level_nxt;
      change_time_r <= change_time_nxt;
      down_time_r   <= down_time_nxt;
      hold_done_r   <= hold_done_nxt;
    end
  end

endmodule

// ===== rtl/core/quadrature_encoder_and_key_qualifier_core.sv =====
// Quadrature encoder decoder with two debounced, active-low keys.
//
// in_ch carries one pin sample per word: encoder pins A and B, the select
// and back key pins and a wrapping millisecond timestamp. out_ch returns
// exactly one word per sample: the encoder step (-1, 0, +1) and the press
// and hold flags of both keys.
// cfg_we/cfg_idx/cfg_wdata write debounce_ms (0), hold_ms (1) and
// detent_steps (2); write only while the block is idle.
// A sample waits in the input register and its result is written into the
// output register when that register is empty or out_ch takes its word.
// Throughput: one sample per cycle while out_ch does not stall; the transition
// lookup, accumulator compare and the key time compares all settle in a single stage.
// Reset: both pins taken as high, keys released, accumulator cleared,
// registers back to 30 ms, 700 ms and 4 transitions per detent.
// When out_ch stalls, the output word holds and the input register still
// takes one more sample; in_ch.ready drops only when both are full.
module quadrature_encoder_and_key_qualifier_core (
  input  logic                         clk,
  input  logic                         rst_n,
  qekq_in_if.sink                      in_ch,
  qekq_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  qekq_pkg::cfg_idx_t           cfg_idx,
  input  logic [qekq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import qekq_pkg::*;

  // Configuration
  logic [15:0] debounce_ms_r;
  logic [15:0] hold_ms_r;
  logic [3:0]  detent_steps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r  <= DEBOUNCE_MS_RST;
      hold_ms_r      <= HOLD_MS_RST;
      detent_steps_r <= DETENT_STEPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEBOUNCE_MS:  debounce_ms_r  <= cfg_wdata[15:0];
        CFG_HOLD_MS:      hold_ms_r      <= cfg_wdata[15:0];
        CFG_DETENT_STEPS: detent_steps_r <= cfg_wdata[3:0];
        default:          ;
      endcase
    end
  end

  // Input register
  logic        s1_vld_r;
  logic        s1_a_r, s1_b_r, s1_sel_r, s1_bck_r;
  logic [31:0] s1_now_r;
  logic        advance;
  logic        fire;
  logic        in_take;

  logic        out_vld_r;
  step_t       out_step_r, out_step_nxt;
  key_evt_t    out_sel_r, out_bck_r;

  assign advance     = !out_vld_r || out_ch.ready;
  assign fire        = s1_vld_r && advance;
  assign in_ch.ready = !s1_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_a_r   <= in_ch.enc_a;
      s1_b_r   <= in_ch.enc_b;
      s1_sel_r <= in_ch.select_key;
      s1_bck_r <= in_ch.back_key;
      s1_now_r <= in_ch.now_ms;
    end
  end

  // Encoder
  logic [1:0] last_ab_r;
  step_acc_t  acc_r, acc_nxt, acc_sum;
  step_acc_t  det;
  logic [1:0] cur_ab;

  assign cur_ab = {s1_a_r, s1_b_r};

  always_comb begin
    if (detent_steps_r == 4'd0) begin
      det = DETENT_MIN;
    end else if (detent_steps_r > 4'd8) begin
      det = DETENT_MAX;
    end else begin
      det = step_acc_t'({1'b0, detent_steps_r});
    end
  end

  assign acc_sum = acc_r + step_acc_t'(QUAD_TBL[{last_ab_r, cur_ab}]);

  always_comb begin
    acc_nxt      = acc_sum;
    out_step_nxt = 2'sd0;
    if (acc_sum >= det) begin
      out_step_nxt = 2'sd1;
      acc_nxt      = 5'sd0;
    end else if (acc_sum <= -det) begin
      out_step_nxt = -2'sd1;
      acc_nxt      = 5'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ab_r <= AB_RST;
      acc_r     <= 5'sd0;
    end else if (fire) begin
      last_ab_r <= cur_ab;
      acc_r     <= acc_nxt;
    end
  end

  // Keys
  key_evt_t sel_evt, bck_evt;

  qekq_key u_select (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (fire),
    .pin         (s1_sel_r),
    .now_ms      (s1_now_r),
    .debounce_ms (debounce_ms_r),
    .hold_ms     (hold_ms_r),
    .evt         (sel_evt)
  );

  qekq_key u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (fire),
    .pin         (s1_bck_r),
    .now_ms      (s1_now_r),
    .debounce_ms (debounce_ms_r),
    .hold_ms     (hold_ms_r),
    .evt         (bck_evt)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_step_r <= out_step_nxt;
      out_sel_r  <= sel_evt;
      out_bck_r  <= bck_evt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.encoder_step   = out_step_r;
  assign out_ch.select_pressed = out_sel_r.pressed;
  assign out_ch.select_held    = out_sel_r.held;
  assign out_ch.back_pressed   = out_bck_r.pressed;
  assign out_ch.back_held      = out_bck_r.held;

`ifndef SYNTHESIS
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= DETENT_MAX && acc_r >= -DETENT_MAX)
    else $error("step accumulator out of range");

  a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_step_r != 2'sd0 |-> acc_r == 5'sd0)
    else $error("accumulator not cleared after a reported step");

  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_step_r != -2'sd2)
    else $error("illegal encoder step code");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled with empty output register");

  a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed word did not reach the output register");
`endif

endmodule
